### sv/adsc_pkg.sv
// ----------------------------------------------------------------------------
// adsc_pkg: shared types and constants for the ASCII decimal sum checker
// Word layouts for the byte and result channels, field widths and the
// character codes the parser recognizes.
// ----------------------------------------------------------------------------
package adsc_pkg;

  // Field and state widths
  localparam int BYTE_W   = 8;
  localparam int SUM_W    = 31;
  localparam int TOKEN_W  = 34;   // holds ten decimal digits
  localparam int DIGITS_W = 4;

  // Longest number accepted, in digits
  localparam logic [DIGITS_W-1:0] MAX_DIGITS = 4'd10;

  // Largest legal number and sum
  localparam logic [TOKEN_W-1:0] LIMIT_31 = 34'd2147483647;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_SP   = 8'd32;

  // One message byte
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_word_t;

  // One message result
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             error;
  } out_word_t;

endpackage

### sv/ascii_decimal_sum_checker.sv
// ----------------------------------------------------------------------------
// ascii_decimal_sum_checker: sums the decimal numbers in an ASCII message
// Checks the message for bad bytes, long numbers and overflow and gives the
// binary sum with an error flag on the last byte.
// ----------------------------------------------------------------------------
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-----------------------------------
//   bytes   | msg_valid | msg_stall | msg  (data_byte, last_byte)
//   result  | sum_valid | sum_stall | sum  (total, error)
//
// One byte word per cycle while msg_stall is low; the parser state update is combinational logic.
// A result is registered in the result register after its last byte passes the input register and the parser.
// Reset clears the register flags and the parser state.
// A stalled result holds the parser and backs up into msg_stall.
// ----------------------------------------------------------------------------
module ascii_decimal_sum_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_stall,
  input  adsc_pkg::in_word_t  msg,
  output logic                sum_valid,
  input  logic                sum_stall,
  output adsc_pkg::out_word_t sum
);

  logic                in_full;
  adsc_pkg::in_word_t  in_held;
  logic                advance;
  logic                fire;
  logic                result_load;
  adsc_pkg::out_word_t result;

  assign fire = in_full && advance;

  // Input register
  adsc_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .valid   (msg_valid),
    .stall   (msg_stall),
    .word    (msg),
    .advance (advance),
    .full    (in_full),
    .held    (in_held)
  );

  // Parser
  adsc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .word        (in_held),
    .result_load (result_load),
    .result      (result)
  );

  // Result register
  adsc_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (result_load),
    .result (result),
    .open   (advance),
    .valid  (sum_valid),
    .stall  (sum_stall),
    .word   (sum)
  );

  // An error result always carries a zero total
  assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum.error |-> sum.total == '0)
    else $error("error result with nonzero total");

  // The parser never consumes a byte while a result is blocked
  assert property (@(posedge clk) disable iff (rst)
    sum_valid && sum_stall |-> !fire)
    else $error("parser advanced under a stalled result");

  // Input stall only with a held byte
  assert property (@(posedge clk) disable iff (rst)
    msg_stall |-> in_full)
    else $error("input stalled while empty");

  // A result only follows a consumed last byte or a held result
  assert property (@(posedge clk) disable iff (rst)
    $rose(sum_valid) |-> $past(fire && in_held.last_byte))
    else $error("result without a last byte");

endmodule

### sv/adsc_in_reg.sv
// ----------------------------------------------------------------------------
// adsc_in_reg: input register
// Captures one byte word per cycle while not stalled and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module adsc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  adsc_pkg::in_word_t word,
  input  logic              advance,
  output logic              full,
  output adsc_pkg::in_word_t held
);

  // Stall only while a held word cannot move on
  assign stall = full && !advance;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!stall) begin
      full <= valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      held <= word;
    end
  end

endmodule

### sv/adsc_core.sv
// ----------------------------------------------------------------------------
// adsc_core: message parser and accumulator
// Updates the number, digit count, running sum and flags for one byte per
// cycle while fire is high and forms the result on the last byte of a message.
// ----------------------------------------------------------------------------
module adsc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  adsc_pkg::in_word_t  word,
  output logic                result_load,
  output adsc_pkg::out_word_t result
);

  // Parser state
  logic [adsc_pkg::TOKEN_W-1:0]  token_value, token_value_next;
  logic [adsc_pkg::DIGITS_W-1:0] token_digits, token_digits_next;
  logic [adsc_pkg::SUM_W-1:0]    running_sum, running_sum_next;
  logic                          bad_flag, bad_flag_next;
  logic                          seen_digit, seen_digit_next;

  // Intermediate values
  logic [adsc_pkg::TOKEN_W-1:0]  tv1;
  logic [adsc_pkg::DIGITS_W-1:0] td1;
  logic                          bad1;
  logic                          seen1;
  logic                          close;
  logic                          sep_hit;
  logic [adsc_pkg::SUM_W:0]      sum_wide;
  logic [adsc_pkg::SUM_W-1:0]    rs2;
  logic                          bad2;
  logic                          err;

  always_comb begin
    tv1     = token_value;
    td1     = token_digits;
    bad1    = bad_flag;
    seen1   = seen_digit;
    sep_hit = 1'b0;

    // Byte classification
    if (!bad_flag) begin
      case (word.data_byte) inside
        [adsc_pkg::CHAR_ZERO:adsc_pkg::CHAR_NINE]: begin
          seen1 = 1'b1;
          if (token_digits >= adsc_pkg::MAX_DIGITS) begin
            bad1 = 1'b1;
          end else begin
            // value * 10 + digit
            tv1 = (token_value << 3) + (token_value << 1)
                + adsc_pkg::TOKEN_W'(word.data_byte - adsc_pkg::CHAR_ZERO);
            td1 = token_digits + 1'b1;
          end
        end
        adsc_pkg::CHAR_SP, adsc_pkg::CHAR_LF: begin
          sep_hit = 1'b1;
        end
        adsc_pkg::CHAR_CR: begin
          sep_hit = 1'b0;
        end
        default: begin
          bad1 = 1'b1;
        end
      endcase
    end

    // Close the current number on a separator or the end of the message
    close    = sep_hit || word.last_byte;
    sum_wide = {1'b0, running_sum} + {1'b0, tv1[adsc_pkg::SUM_W-1:0]};
    rs2      = running_sum;
    bad2     = bad1;
    if (close && td1 != '0 && !bad1) begin
      if (tv1 > adsc_pkg::LIMIT_31) begin
        bad2 = 1'b1;
      end else if (sum_wide[adsc_pkg::SUM_W]) begin
        bad2 = 1'b1;
      end else begin
        rs2 = sum_wide[adsc_pkg::SUM_W-1:0];
      end
    end

    // Result
    err           = bad2 || !seen1;
    result.error  = err;
    result.total  = err ? '0 : rs2;
    result_load   = fire && word.last_byte;

    // Next state; a message end clears everything
    if (word.last_byte) begin
      token_value_next  = '0;
      token_digits_next = '0;
      running_sum_next  = '0;
      bad_flag_next     = 1'b0;
      seen_digit_next   = 1'b0;
    end else begin
      token_value_next  = close ? '0 : tv1;
      token_digits_next = close ? '0 : td1;
      running_sum_next  = rs2;
      bad_flag_next     = bad2;
      seen_digit_next   = seen1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      token_value  <= '0;
      token_digits <= '0;
      running_sum  <= '0;
      bad_flag     <= 1'b0;
      seen_digit   <= 1'b0;
    end else if (fire) begin
      token_value  <= token_value_next;
      token_digits <= token_digits_next;
      running_sum  <= running_sum_next;
      bad_flag     <= bad_flag_next;
      seen_digit   <= seen_digit_next;
    end
  end

endmodule

### sv/adsc_out_reg.sv
// ----------------------------------------------------------------------------
// adsc_out_reg: result register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module adsc_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  adsc_pkg::out_word_t result,
  output logic                open,
  output logic                valid,
  input  logic                stall,
  output adsc_pkg::out_word_t word
);

  // Free, or being emptied this cycle
  assign open = !valid || !stall;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (open) begin
      valid <= load;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (open && load) begin
      word <= result;
    end
  end

endmodule
